// ===== rtl/oaids_pkg.sv =====
`timescale 1ns / 1ps
package oaids_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_POS   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]         operation;
        logic [4:0]         position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] found_index;
        logic [4:0] entry_count;
    } t_rsp;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic load_match;
        logic scan;
    } t_cell_ctrl;

endpackage

// ===== rtl/oaids_cell.sv =====
`timescale 1ns / 1ps
module oaids_cell import oaids_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic [4:0]         i_position,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_left_entry,
    input  logic signed [31:0] i_right_entry,
    input  logic               i_right_match,
    output logic signed [31:0] o_entry,
    output logic               o_match
);

    logic signed [31:0] r_entry, n_entry;
    logic               r_match, n_match;
    logic [31:0]        w_pos;

    assign w_pos = 32'(i_position);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.shift_up) begin
            if (32'(IDX) > w_pos) begin
                n_entry = i_left_entry;
            end else if (32'(IDX) == w_pos) begin
                n_entry = i_value;
            end
        end else if (i_ctrl.shift_down) begin
            if (32'(IDX) >= w_pos) begin
                n_entry = i_right_entry;
            end
        end
    end

    always_comb begin
        n_match = r_match;
        if (i_ctrl.load_match) begin
            n_match = (r_entry == i_value);
        end else if (i_ctrl.scan) begin
            n_match = i_right_match;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_match <= n_match;
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

// ===== rtl/ordered_array_insert_delete_search.sv =====
`timescale 1ns / 1ps
// Insert, delete and rejected requests: result strobed in the cycle after start, one per cycle while not busy.
// Search: every cell compares at once, then match flags shift towards cell 0;
// a hit at index k is strobed once flag k reaches cell 0, a miss once all count flags have passed.
// Busy is high while the search scans and drops as its result is strobed.
// Synchronous active-low reset clears count and control; stored words are left as they are.
// Results are strobed for one cycle; the receiver cannot stall.
module ordered_array_insert_delete_search import oaids_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic               r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_done, n_done;
    logic [1:0]         r_status, n_status;
    logic [3:0]         r_index, n_index;
    t_cell_ctrl         w_ctrl;
    logic               w_accept;
    logic [31:0]        w_pos, w_count;
    logic signed [31:0] w_entry [DEPTH];
    logic               w_match [DEPTH];

    assign w_accept = start && (r_state == S_IDLE);
    assign w_pos    = 32'(i_req.position);
    assign w_count  = 32'(r_count);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        n_status = r_status;
        n_index  = r_index;
        w_ctrl   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_index = '0;
                    case (i_req.operation)
                        OP_INSERT: begin
                            n_done = 1'b1;
                            if (w_pos > w_count) begin
                                n_status = ST_BAD_POS;
                            end else if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status        = ST_OK;
                                w_ctrl.shift_up = 1'b1;
                                n_count         = r_count + 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            n_done = 1'b1;
                            if (w_pos >= w_count) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                n_status          = ST_OK;
                                w_ctrl.shift_down = 1'b1;
                                n_count           = r_count - 1'b1;
                            end
                        end
                        OP_SEARCH: begin
                            w_ctrl.load_match = 1'b1;
                            n_cnt             = '0;
                            n_state           = S_SCAN;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = ST_BAD_POS;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // cell 0 holds the flag of entry r_cnt
                if (r_cnt == r_count) begin
                    n_done   = 1'b1;
                    n_status = ST_NOT_FOUND;
                    n_index  = '0;
                    n_state  = S_IDLE;
                end else if (w_match[0]) begin
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_index  = 4'(r_cnt);
                    n_state  = S_IDLE;
                end else begin
                    w_ctrl.scan = 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_index  <= n_index;
    end

    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [31:0] w_left, w_right;
            logic               w_rmatch;
            if (g == 0) begin : g_first
                assign w_left = i_req.value;
            end else begin : g_mid
                assign w_left = w_entry[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_right  = w_entry[g];
                assign w_rmatch = 1'b0;
            end else begin : g_inner
                assign w_right  = w_entry[g+1];
                assign w_rmatch = w_match[g+1];
            end
            oaids_cell #(
                .IDX(g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_position   (i_req.position),
                .i_value      (i_req.value),
                .i_left_entry (w_left),
                .i_right_entry(w_right),
                .i_right_match(w_rmatch),
                .o_entry      (w_entry[g]),
                .o_match      (w_match[g])
            );
        end
    endgenerate

    assign busy               = (r_state == S_SCAN);
    assign o_done             = r_done;
    assign o_rsp.status       = r_status;
    assign o_rsp.found_index  = r_index;
    assign o_rsp.entry_count  = 5'(r_count);

endmodule

// ===== verif/tb_ordered_array_insert_delete_search.sv =====
`timescale 1ns / 1ps
module tb_ordered_array_insert_delete_search;
    import oaids_pkg::*;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 1400;
    // no operation is assigned to the top code
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_req i_req = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    // shadow copy of the store, updated when a request is accepted
    logic signed [31:0] shadow_words [DEPTH];
    int shadow_count = 0;
    t_rsp expected_rsp_q [$];

    int n_errors = 0;
    int idle_cycles = 0;
    int sender_idle_pct = 0;

    ordered_array_insert_delete_search #(.DEPTH(DEPTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_rsp apply_request(t_req r);
        t_rsp rsp;
        int p;
        int i;
        logic hit;
        rsp = '0;
        p = r.position;
        hit = 1'b0;
        case (r.operation)
            OP_INSERT: begin
                if (p > shadow_count) begin
                    rsp.status = ST_BAD_POS;
                end else if (shadow_count >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (i = shadow_count; i > p; i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[p] = r.value;
                    shadow_count++;
                    rsp.status = ST_OK;
                end
            end
            OP_DELETE: begin
                if (p >= shadow_count) begin
                    rsp.status = ST_BAD_POS;
                end else begin
                    for (i = p; i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_count--;
                    rsp.status = ST_OK;
                end
            end
            OP_SEARCH: begin
                rsp.status = ST_NOT_FOUND;
                for (i = 0; i < shadow_count; i++) begin
                    if (!hit && shadow_words[i] == r.value) begin
                        hit = 1'b1;
                        rsp.status = ST_OK;
                        rsp.found_index = i[3:0];
                    end
                end
            end
            default: rsp.status = ST_BAD_POS;
        endcase
        rsp.entry_count = shadow_count[4:0];
        return rsp;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    // start stays high from one request to the next unless a gap is taken
    task automatic send_req(input logic [1:0] op, input logic [4:0] pos,
                            input logic signed [31:0] val);
        t_req r;
        r.operation = op;
        r.position = pos;
        r.value = val;
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        expected_rsp_q = {expected_rsp_q, apply_request(r)};
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done !== 1'b0) begin
            if (expected_rsp_q.size() == 0) begin
                report_mismatch("unexpected result, status", int'(o_rsp.status), 0);
            end else begin
                want = expected_rsp_q.pop_front();
                if (o_rsp.status !== want.status)
                    report_mismatch("status", int'(o_rsp.status), int'(want.status));
                if (o_rsp.found_index !== want.found_index)
                    report_mismatch("found_index", int'(o_rsp.found_index),
                                    int'(want.found_index));
                if (o_rsp.entry_count !== want.entry_count)
                    report_mismatch("entry_count", int'(o_rsp.entry_count),
                                    int'(want.entry_count));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_empty_store();
        send_req(OP_DELETE, 5'd0, 32'sd0);
        send_req(OP_SEARCH, 5'd0, 32'sd0);
        send_req(OP_INSERT, 5'd1, 32'sd7);
        send_req(OP_UNUSED, 5'd31, 32'h7fff_ffff);
        wait_drain();
    endtask

    task automatic test_fill_to_full();
        int i;
        int p;
        logic signed [31:0] v;
        for (i = 0; i < DEPTH; i++) begin
            case (i % 3)
                0:       p = 0;
                1:       p = shadow_count;
                default: p = shadow_count / 2;
            endcase
            case (i)
                0:       v = 32'h8000_0000;
                1:       v = 32'h7fff_ffff;
                2:       v = 32'sd0;
                3:       v = -32'sd1;
                4, 5:    v = 32'sd5;
                default: v = $urandom;
            endcase
            send_req(OP_INSERT, p[4:0], v);
        end
        // full store: a valid position is refused as full, a bad one as bad
        send_req(OP_INSERT, 5'd16, 32'sd9);
        send_req(OP_INSERT, 5'd17, 32'sd9);
        wait_drain();
    endtask

    task automatic test_search_hits();
        send_req(OP_SEARCH, 5'd31, shadow_words[DEPTH - 1]);
        send_req(OP_SEARCH, 5'd0, 32'sd5);
        wait_drain();
    endtask

    task automatic test_delete_cases();
        send_req(OP_DELETE, 5'd16, 32'sd0);
        send_req(OP_DELETE, 5'd0, 32'sd0);
        send_req(OP_DELETE, 5'd7, 32'sd0);
        wait_drain();
    endtask

    task automatic test_random(input int n_items, input int idle_pct);
        int n;
        int k;
        int w;
        logic fill_mode;
        logic [1:0] op;
        logic [4:0] pos;
        logic signed [31:0] val;
        sender_idle_pct = idle_pct;
        fill_mode = 1'b1;
        for (n = 0; n < n_items; n++) begin
            if (n % 50 == 0)
                fill_mode = ~fill_mode;
            k = $urandom_range(0, 99);
            val = $urandom;
            if (k < 8) begin
                op = 2'($urandom_range(0, 3));
                pos = 5'($urandom_range(0, 31));
            end else begin
                w = $urandom_range(0, 99);
                if (fill_mode)
                    op = (w < 55) ? OP_INSERT : (w < 75) ? OP_DELETE : OP_SEARCH;
                else
                    op = (w < 20) ? OP_INSERT : (w < 60) ? OP_DELETE : OP_SEARCH;
                case (op)
                    OP_INSERT: begin
                        pos = 5'($urandom_range(0, shadow_count));
                        // a narrow value set gives duplicates for the searches
                        if ($urandom_range(0, 2) == 0)
                            val = $signed($urandom_range(0, 6)) - 32'sd3;
                    end
                    OP_DELETE: begin
                        pos = (shadow_count > 0) ? 5'($urandom_range(0, shadow_count - 1))
                                                 : 5'd0;
                    end
                    default: begin
                        pos = 5'($urandom_range(0, 31));
                        if (shadow_count > 0 && $urandom_range(0, 99) < 60)
                            val = shadow_words[$urandom_range(0, shadow_count - 1)];
                        else if ($urandom_range(0, 1) == 0)
                            val = $signed($urandom_range(0, 6)) - 32'sd3;
                    end
                endcase
            end
            send_req(op, pos, val);
            if (n % 200 == 199)
                wait_drain();
        end
        wait_drain();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_idle_pct = 34;
        test_empty_store();
        test_fill_to_full();
        test_search_hits();
        test_delete_cases();
        test_random(RANDOM_ITEMS / 3, 34);
        test_random(RANDOM_ITEMS / 3, 49);
        test_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0);
        repeat (DEPTH + 4) @(posedge i_clk);
        if (expected_rsp_q.size() != 0)
            report_mismatch("results still awaited", 0, expected_rsp_q.size());
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
